### rtl/assert_macros.svh
// Assertion helpers for the decoder RTL (included by the back end).
// Both expect i_clk and i_rst_n in scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/adfd2_pkg.sv
package adfd2_pkg;

    // Frame layout
    localparam logic [4:0] POS_SCALE_HI   = 5'd0;
    localparam logic [4:0] POS_SCALE_LO   = 5'd1;
    localparam logic [4:0] POS_FRAME_LAST = 5'd17;

    // Saturation bounds
    localparam logic signed [23:0] PCM_MAX = 24'sd32767;
    localparam logic signed [23:0] PCM_MIN = -24'sd32768;

    // Q12 rounding toward zero
    localparam logic signed [35:0] Q12_BIAS = 36'sd4095;

    // Channel field in a queue entry covers up to eight channels
    localparam int JOB_CH_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SECOND   = 4'd3;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_track;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               channel;
        logic [31:0]        sample_index;
        logic               last_of_run;
    } t_out_word;

    // One classified stream byte on its way to the back end
    typedef struct packed {
        logic                clear;
        logic [JOB_CH_W-1:0] ch;
        logic [15:0]         scale;
        logic [3:0]          code_hi;
        logic [3:0]          code_lo;
        logic [1:0]          sample_count;
        logic [31:0]         index;
    } t_job;

endpackage

### rtl/adfd2_queue.sv
module adfd2_queue
    import adfd2_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   w_push;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QUEUE_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QUEUE_PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (QUEUE_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/adfd2_front.sv
module adfd2_front
    import adfd2_pkg::*;
#(
    parameter int MAX_CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_word    i_word,
    input  logic [1:0]  i_channel_count,
    input  logic [31:0] i_total_samples,
    output logic        o_push,
    output t_job        o_job
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [4:0]      r_pos;
    logic [CH_W-1:0] r_ch;
    logic [15:0]     r_scale;
    logic            r_skip;
    logic [31:0]     r_done [MAX_CHANNELS];

    logic [4:0]      n_pos;
    logic [CH_W-1:0] n_ch;
    logic [15:0]     n_scale;
    logic            n_skip;
    logic [31:0]     n_done [MAX_CHANNELS];

    logic            w_clear;
    logic [4:0]      w_pos;
    logic [CH_W-1:0] w_ch;
    logic [15:0]     w_scale;
    logic            w_skip;
    logic [31:0]     w_done_cur;
    logic [3:0]      w_active;
    logic [3:0]      w_ch_inc;
    logic            w_data;
    logic            w_hi_ok;
    logic            w_lo_ok;
    logic [1:0]      w_count;

    assign w_clear = i_word.start_of_track;
    assign w_pos   = w_clear ? '0 : r_pos;
    assign w_ch    = w_clear ? '0 : r_ch;
    assign w_scale = w_clear ? '0 : r_scale;
    assign w_skip  = w_clear ? 1'b0 : r_skip;
    assign w_done_cur = w_clear ? '0 : r_done[w_ch];

    // Zero acts as one, anything above the build limit saturates
    always_comb begin
        if (i_channel_count == '0) begin
            w_active = 4'd1;
        end else if (4'(i_channel_count) > 4'(MAX_CHANNELS)) begin
            w_active = 4'(MAX_CHANNELS);
        end else begin
            w_active = 4'(i_channel_count);
        end
    end

    assign w_ch_inc = 4'(w_ch) + 4'd1;
    assign w_data   = (w_pos != POS_SCALE_HI) && (w_pos != POS_SCALE_LO) && !w_skip;
    assign w_hi_ok  = w_data && (w_done_cur < i_total_samples);
    assign w_lo_ok  = w_data && (({1'b0, w_done_cur} + 33'(w_hi_ok)) < {1'b0, i_total_samples});
    assign w_count  = 2'(w_hi_ok) + 2'(w_lo_ok);

    always_comb begin
        n_scale = w_scale;
        n_skip  = w_skip;
        n_ch    = w_ch;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            n_done[c] = w_clear ? '0 : r_done[c];
        end
        n_done[w_ch] = w_done_cur + 32'(w_count);

        if (w_pos == POS_SCALE_HI) begin
            n_skip  = (w_done_cur >= i_total_samples);
            n_scale = {i_word.stream_byte, 8'd0};
        end else if (w_pos == POS_SCALE_LO) begin
            n_scale = {w_scale[15:8], i_word.stream_byte};
        end

        if (w_pos == POS_FRAME_LAST) begin
            n_pos  = '0;
            n_skip = 1'b0;
            n_ch   = (w_ch_inc >= w_active) ? '0 : w_ch_inc[CH_W-1:0];
        end else begin
            n_pos = w_pos + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ch    <= '0;
            r_scale <= '0;
            r_skip  <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_done[c] <= '0;
            end
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_ch    <= n_ch;
            r_scale <= n_scale;
            r_skip  <= n_skip;
            r_done  <= n_done;
        end
    end

    // A start byte always travels so the back end can drop its history
    assign o_push             = i_accept && (w_clear || (w_count != '0));
    assign o_job.clear        = w_clear;
    assign o_job.ch           = JOB_CH_W'(w_ch);
    assign o_job.scale        = w_scale;
    assign o_job.code_hi      = i_word.stream_byte[7:4];
    assign o_job.code_lo      = i_word.stream_byte[3:0];
    assign o_job.sample_count = w_count;
    assign o_job.index        = w_done_cur;

endmodule

### rtl/adfd2_back.sv
`include "assert_macros.svh"

module adfd2_back
    import adfd2_pkg::*;
#(
    parameter int MAX_CHANNELS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    input  logic signed [13:0] i_coef_first,
    input  logic signed [13:0] i_coef_second,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output t_out_word          o_out_word
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic signed [15:0] r_prev  [MAX_CHANNELS];
    logic signed [15:0] r_older [MAX_CHANNELS];
    logic               r_k;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [CH_W-1:0]    w_ch;
    logic               w_first;
    logic               w_clr;
    logic signed [3:0]  w_code;
    logic signed [15:0] w_prev;
    logic signed [15:0] w_older;
    logic signed [20:0] w_ns;
    logic signed [29:0] w_p1;
    logic signed [29:0] w_p2;
    logic signed [35:0] w_acc;
    logic signed [35:0] w_adj;
    logic signed [23:0] w_q;
    logic signed [15:0] w_sat;
    logic               w_slot_free;
    logic               w_fire;
    logic               w_last;
    logic               w_job_done;

    assign w_ch    = i_job.ch[CH_W-1:0];
    assign w_first = !r_k;
    assign w_clr   = i_job.clear && w_first;
    assign w_code  = w_first ? i_job.code_hi : i_job.code_lo;
    assign w_prev  = w_clr ? '0 : r_prev[w_ch];
    assign w_older = w_clr ? '0 : r_older[w_ch];

    // n*scale in Q12 plus the two-tap prediction, all exact
    assign w_ns  = 21'(w_code) * 21'($signed({1'b0, i_job.scale}));
    assign w_p1  = 30'(i_coef_first) * 30'(w_prev);
    assign w_p2  = 30'(i_coef_second) * 30'(w_older);
    assign w_acc = 36'($signed({w_ns, 12'd0})) + 36'(w_p1) + 36'(w_p2);
    assign w_adj = w_acc[35] ? (w_acc + Q12_BIAS) : w_acc;
    assign w_q   = w_adj[35:12];

    always_comb begin
        if (w_q > PCM_MAX) begin
            w_sat = PCM_MAX[15:0];
        end else if (w_q < PCM_MIN) begin
            w_sat = PCM_MIN[15:0];
        end else begin
            w_sat = w_q[15:0];
        end
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_fire      = i_job_valid && (i_job.sample_count != '0) && w_slot_free;
    assign w_last      = (i_job.sample_count == 2'd1) || !w_first;
    assign w_job_done  = i_job_valid && ((i_job.sample_count == '0) || (w_fire && w_last));
    assign o_pop       = w_job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_prev[c]  <= '0;
                r_older[c] <= '0;
            end
        end else begin
            if (w_job_done) begin
                r_k <= 1'b0;
            end else if (w_fire) begin
                r_k <= 1'b1;
            end
            // the firing channel takes its new sample, a clear wipes the rest
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                if (w_fire && (CH_W'(c) == w_ch)) begin
                    r_prev[c]  <= w_sat;
                    r_older[c] <= w_prev;
                end else if (i_job_valid && w_clr) begin
                    r_prev[c]  <= '0;
                    r_older[c] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_fire || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.pcm_sample   <= w_sat;
            r_out.channel      <= i_job.ch[0];
            r_out.sample_index <= w_first ? i_job.index : (i_job.index + 32'd1);
            r_out.last_of_run  <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `ASSERT_IMPLIES(a_second_needs_pair, r_k, i_job_valid && (i_job.sample_count == 2'd2),
        "second code pending without a two-sample head")
    `ASSERT_NEXT(a_pair_advances, w_fire && w_first && (i_job.sample_count == 2'd2), r_k,
        "first code of a pair did not advance to the second")
    `ASSERT_IMPLIES(a_pop_has_head, o_pop, i_job_valid, "pop with an empty queue")
    `ASSERT_NEXT(a_fire_shows, w_fire, o_out_valid, "computed sample not presented")

endmodule

### rtl/adpcm_frame_decoder_second_order_top.sv
// 4-bit ADPCM frame decoder, two-tap Q12 predictor.
// Input channel: i_in_valid / o_in_stall carry one stream word (a body byte plus a
//   start-of-track flag). Frames are 18 bytes: big-endian scale, then 16 data bytes.
// Output channel: o_out_valid / i_out_stall carry one decoded sample word with its
//   channel, per-channel index and a flag on the last sample of its byte.
// Config: i_cfg_valid / o_cfg_ready write channel_count, total_samples and the two
//   coefficients by index; ready is always high. Write only while idle.
// Path: taken bytes that yield samples or start a track are queued; the back end computes
//   their samples, high code first, from the queue head and registers each in its output register.
// Throughput: set by the one-sample-per-cycle history loop in the back end while the
//   output is not stalled; a data byte that yields two samples holds the queue head for both.
// A 4-word queue separates byte parsing from sample math; the input stalls only
//   when that queue is full, and output stalls fill it before reaching the input.
// Reset clears frame position, channel, scale, histories, counters and config
//   (channel_count = 1, all else 0). A start-of-track word clears track state only.
module adpcm_frame_decoder_second_order_top
    import adfd2_pkg::*;
#(
    parameter int MAX_CHANNELS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // config registers
    logic [1:0]         r_channel_count;
    logic [31:0]        r_total_samples;
    logic signed [13:0] r_coef_first;
    logic signed [13:0] r_coef_second;

    logic w_accept;
    logic w_push;
    t_job w_push_job;
    logic w_q_valid;
    logic w_q_full;
    t_job w_head;
    logic w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 2'd1;
            r_total_samples <= '0;
            r_coef_first    <= '0;
            r_coef_second   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                CFG_TOTAL_SAMPLES: r_total_samples <= i_cfg_data;
                CFG_COEF_FIRST:    r_coef_first    <= $signed(i_cfg_data[13:0]);
                CFG_COEF_SECOND:   r_coef_second   <= $signed(i_cfg_data[13:0]);
                default: ;  // unmapped index, word dropped
            endcase
        end
    end

    // front end takes a word whenever the queue has room
    assign o_in_stall = w_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    adfd2_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_word          (i_in_word),
        .i_channel_count (r_channel_count),
        .i_total_samples (r_total_samples),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    adfd2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_head)
    );

    // back end: one sample per cycle while the output is not stalled, output register in front of the receiver
    adfd2_back #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_q_valid),
        .i_job         (w_head),
        .i_coef_first  (r_coef_first),
        .i_coef_second (r_coef_second),
        .i_out_stall   (i_out_stall),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

endmodule

### verif/adpcm_sample_checker.sv
`timescale 1ns / 100ps

// Watches the stream, config and sample channels, predicts every decoded
// sample word and compares it field by field with what the decoder sends.
module adpcm_sample_checker
    import adfd2_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int NUM_CH = 2;

    logic [1:0]         chan_count;
    logic [31:0]        sample_limit;
    logic signed [13:0] coef_prev;
    logic signed [13:0] coef_older;

    int                 frame_pos;
    int                 cur_ch;
    logic [15:0]        frame_scale;
    logic               skip_frame;
    logic signed [15:0] hist_prev    [NUM_CH];
    logic signed [15:0] hist_older   [NUM_CH];
    logic [31:0]        samples_done [NUM_CH];

    t_out_word          expected_samples [$];

    function automatic void clear_track();
        frame_pos   = 0;
        cur_ch      = 0;
        frame_scale = '0;
        skip_frame  = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            hist_prev[c]    = '0;
            hist_older[c]   = '0;
            samples_done[c] = '0;
        end
    endfunction

    // One 4-bit code: code*scale plus Q12 prediction, truncated toward zero, saturated.
    function automatic bit decode_nibble(input int ch, input logic [3:0] code,
                                         output t_out_word s);
        longint nib;
        longint sc;
        longint cp;
        longint co;
        longint hp;
        longint ho;
        longint acc;
        longint q;
        s = '0;
        if (samples_done[ch] >= sample_limit) return 1'b0;
        nib = longint'($signed(code));
        sc  = longint'(frame_scale);
        cp  = longint'(coef_prev);
        co  = longint'(coef_older);
        hp  = longint'(hist_prev[ch]);
        ho  = longint'(hist_older[ch]);
        acc = nib * sc * 4096 + cp * hp + co * ho;
        q   = acc / 4096;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        hist_older[ch] = hist_prev[ch];
        hist_prev[ch]  = q[15:0];
        s.pcm_sample   = q[15:0];
        s.channel      = ch[0];
        s.sample_index = samples_done[ch];
        s.last_of_run  = 1'b0;
        samples_done[ch]++;
        return 1'b1;
    endfunction

    function automatic void consume_byte(input t_in_word w);
        t_out_word hi_s;
        t_out_word lo_s;
        bit        hi_ok;
        bit        lo_ok;
        int        ch;
        int        active;
        if (w.start_of_track) clear_track();
        if (cur_ch >= NUM_CH) cur_ch = 0;
        ch = cur_ch;
        if (frame_pos == int'(POS_SCALE_HI)) begin
            skip_frame  = samples_done[ch] >= sample_limit;
            frame_scale = {w.stream_byte, 8'h00};
        end else if (frame_pos == int'(POS_SCALE_LO)) begin
            frame_scale[7:0] = w.stream_byte;
        end else if (!skip_frame) begin
            hi_ok = decode_nibble(ch, w.stream_byte[7:4], hi_s);
            lo_ok = decode_nibble(ch, w.stream_byte[3:0], lo_s);
            if (lo_ok) lo_s.last_of_run = 1'b1;
            else if (hi_ok) hi_s.last_of_run = 1'b1;
            if (hi_ok) expected_samples.push_back(hi_s);
            if (lo_ok) expected_samples.push_back(lo_s);
        end
        frame_pos++;
        if (frame_pos > int'(POS_FRAME_LAST)) begin
            frame_pos  = 0;
            skip_frame = 1'b0;
            active     = (chan_count == 2'd0) ? 1 : int'(chan_count);
            if (active > NUM_CH) active = NUM_CH;
            ch++;
            if (ch >= active) ch = 0;
            cur_ch = ch;
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_out_word want;
        if (!i_rst_n) begin
            chan_count   = 2'd1;
            sample_limit = '0;
            coef_prev    = '0;
            coef_older   = '0;
            clear_track();
            expected_samples.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHANNEL_COUNT: chan_count   = i_cfg_data[1:0];
                    CFG_TOTAL_SAMPLES: sample_limit = i_cfg_data;
                    CFG_COEF_FIRST:    coef_prev    = i_cfg_data[13:0];
                    CFG_COEF_SECOND:   coef_older   = i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) consume_byte(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("sample word with none expected: pcm %0d ch %0d index %0d",
                           i_out_word.pcm_sample, i_out_word.channel,
                           i_out_word.sample_index);
                    o_fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out_word.pcm_sample !== want.pcm_sample) begin
                        $error("pcm_sample: expected %0d, got %0d",
                               want.pcm_sample, i_out_word.pcm_sample);
                        o_fail_count++;
                    end
                    if (i_out_word.channel !== want.channel) begin
                        $error("channel: expected %0d, got %0d",
                               want.channel, i_out_word.channel);
                        o_fail_count++;
                    end
                    if (i_out_word.sample_index !== want.sample_index) begin
                        $error("sample_index: expected %0d, got %0d",
                               want.sample_index, i_out_word.sample_index);
                        o_fail_count++;
                    end
                    if (i_out_word.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, i_out_word.last_of_run);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the 4-bit ADPCM frame decoder.
// The checker instance beside the DUT does all prediction and comparison;
// this module only drives words, config writes and output back-pressure.
module testbench;
    import adfd2_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 11;
    localparam int WORD_TARGET    = 1950;
    // Wait for the 4-entry job queue and the back end to empty, with margin
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    // Index that maps to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

    // Q12 coefficient corners (14-bit two's complement)
    localparam logic [13:0] COEF_MAX = 14'h1FFF;   // just under +2.0
    localparam logic [13:0] COEF_MIN = 14'h2000;   // -2.0
    localparam logic [13:0] COEF_ONE = 14'h1000;   // 1.0

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;

    int                   fail_count;
    int                   pending;
    int                   words_sent  = 0;
    int                   steady_left = 0;   // words left in a no-gap burst

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    adpcm_frame_decoder_second_order_top #(
        .MAX_CHANNELS(2)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    adpcm_sample_checker sample_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Offer one stream word after a random gap and hold it until taken.
    // Gaps: mostly none, some short, a few long; now and then a burst with none.
    task automatic send_word(input logic [7:0] b, input logic sot);
        t_in_word w;
        int       gap;
        int       r;
        w.stream_byte    = b;
        w.start_of_track = sot;
        gap = 0;
        if (steady_left > 0) begin
            steady_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) steady_left = $urandom_range(20, 80);
            else if (r < 8) gap = $urandom_range(8, 30);
            else if (r < 35) gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Well-formed frame: big-endian scale, then 16 data bytes of random codes
    task automatic send_frame(input logic [15:0] scale, input logic sot);
        send_word(scale[15:8], sot);
        send_word(scale[7:0], 1'b0);
        repeat (16) send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every predicted sample come out, then give bytes that
    // yield no sample time to leave the job queue before config changes.
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Output back-pressure: mostly free, short stalls often, long stalls rarely,
    // plus quiet stretches with no stall at all.
    initial begin : stall_pattern
        int hold;
        int quiet;
        int r;
        hold  = 0;
        quiet = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else if (quiet > 0) begin
                quiet--;
                out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    quiet = $urandom_range(20, 120);
                    out_stall <= 1'b0;
                end else if (r < 6) begin
                    hold = $urandom_range(10, 40);
                    out_stall <= 1'b1;
                end else if (r < 30) begin
                    hold = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        int          n_frames;
        int          kind;
        int          r;
        logic        new_track;
        logic [15:0] scale;
        logic [31:0] rnd;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // Weights of just under +2.0 and -2.0 with full scale: saturation both ways.
        // Limit of 5 cuts the third data byte to one sample; the fourth gives none.
        cfg_write(CFG_CHANNEL_COUNT, 32'd1);
        cfg_write(CFG_TOTAL_SAMPLES, 32'd5);
        cfg_write(CFG_COEF_FIRST, {18'd0, COEF_MAX});
        cfg_write(CFG_COEF_SECOND, {18'h3FFFF, COEF_MIN});
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h08, 1'b0);
        send_word(8'hF7, 1'b0);
        // track restart mid-frame, zero scale
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        wait_drained();

        // channel count 0 behaves as 1; unlimited samples; weights swapped
        cfg_write(CFG_CHANNEL_COUNT, 32'd0);
        cfg_write(CFG_TOTAL_SAMPLES, 32'hFFFF_FFFF);
        cfg_write(CFG_COEF_FIRST, {18'h3FFFF, COEF_MIN});
        cfg_write(CFG_COEF_SECOND, {18'd0, COEF_MAX});
        send_word(8'h00, 1'b1);
        send_word(8'h01, 1'b0);     // scale of one
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h08, 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'h88, 1'b0);
        send_word(8'h00, 1'b0);
        wait_drained();

        // --- channel handling with random codes ---
        // Count of 3 saturates to two channels; each stops at 20 samples,
        // so the third frame (channel 0 again) is skipped whole.
        cfg_write(CFG_CHANNEL_COUNT, 32'd3);
        cfg_write(CFG_TOTAL_SAMPLES, 32'd20);
        cfg_write(CFG_COEF_FIRST, {18'd0, COEF_ONE});
        cfg_write(CFG_COEF_SECOND, 32'd0);
        send_frame(16'h0100, 1'b1);
        send_frame(16'h0200, 1'b0);
        send_frame(16'h0300, 1'b0);
        wait_drained();
        // Drop to one channel while channel 1 is next: it keeps that frame,
        // then the stream wraps back to channel 0.
        cfg_write(CFG_CHANNEL_COUNT, 32'd1);
        cfg_write(CFG_TOTAL_SAMPLES, 32'd40);
        send_frame(16'h0400, 1'b0);
        send_frame(16'h0500, 1'b0);

        // --- random phases: new settings while idle, then mostly whole frames ---
        while (words_sent < WORD_TARGET) begin
            wait_drained();

            if ($urandom_range(0, 2) == 0) begin
                rnd      = $urandom;
                rnd[1:0] = 2'($urandom_range(0, 3));
                cfg_write(CFG_CHANNEL_COUNT, rnd);
            end
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 9);
                if (r < 2) rnd = $urandom_range(0, 64);
                else if (r < 4) rnd = $urandom_range(65, 400);
                else if (r == 4) rnd = 32'hFFFF_FFFF;
                else rnd = $urandom;
                cfg_write(CFG_TOTAL_SAMPLES, rnd);
            end
            for (int part = 0; part < 2; part++) begin
                if ($urandom_range(0, 2) == 0) begin
                    // upper bits random: only the low 14 carry the weight
                    rnd = $urandom;
                    r   = $urandom_range(0, 9);
                    if (r < 2) rnd[13:0] = COEF_MAX;
                    else if (r < 4) rnd[13:0] = COEF_MIN;
                    else if (r == 4) rnd[13:0] = '0;
                    else if (r == 5) rnd[13:0] = COEF_ONE;
                    cfg_write((part == 0) ? CFG_COEF_FIRST : CFG_COEF_SECOND, rnd);
                end
            end

            new_track = ($urandom_range(0, 3) != 0);
            n_frames  = $urandom_range(1, 5);
            for (int f = 0; f < n_frames; f++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    // frame cut short; the rest of the phase runs misaligned
                    repeat ($urandom_range(1, 17))
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                end else if (kind == 1) begin
                    // noise with an occasional track restart anywhere in a frame
                    repeat ($urandom_range(1, 12))
                        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end else begin
                    // small scales keep the predictor out of saturation most of the time
                    r = $urandom_range(0, 9);
                    if (r < 4) scale = 16'($urandom_range(0, 16'h03FF));
                    else if (r < 7) scale = 16'($urandom_range(0, 16'h1FFF));
                    else if (r < 9) scale = 16'($urandom);
                    else scale = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    send_frame(scale, new_track && (f == 0));
                end
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/adfd2_pkg.sv
rtl/adfd2_queue.sv
rtl/adfd2_front.sv
rtl/adfd2_back.sv
rtl/adpcm_frame_decoder_second_order_top.sv
verif/adpcm_sample_checker.sv
verif/testbench.sv
